@@ rtl/hues_pkg.sv @@
// Shared types, codes and byte tables for the HTML/URL escape stream.
`default_nettype none
package hues_pkg;

  localparam int Q_DEPTH = 4;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_HTML = 2'd1;
  localparam logic [1:0] MODE_URL  = 2'd2;

  localparam logic REG_ESCAPE_MODE = 1'b0;

  typedef struct packed {
    logic [7:0] in_char;
    logic       final_char;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       call_done;
  } out_word_t;

  typedef enum logic [2:0] {
    KIND_PASS = 3'd0,
    KIND_QUOT = 3'd1,
    KIND_GT   = 3'd2,
    KIND_LT   = 3'd3,
    KIND_AMP  = 3'd4,
    KIND_APOS = 3'd5,
    KIND_URL  = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       fin;
  } tok_t;

  function automatic logic url_reserved(input logic [7:0] c);
    logic r;
    case (c)
      "!", "]", "[", "#", "?", "/", ",", "$", "+", "=", "&", "@",
      ":", ";", ")", "(", "'", "*", "<", ">", "\"", " ", "%": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_t classify(input logic [1:0] mode, input logic [7:0] c);
    kind_t k;
    k = KIND_PASS;
    if (mode == MODE_HTML) begin
      case (c)
        "\"":    k = KIND_QUOT;
        ">":     k = KIND_GT;
        "<":     k = KIND_LT;
        "&":     k = KIND_AMP;
        "'":     k = KIND_APOS;
        default: k = KIND_PASS;
      endcase
    end else if (mode != MODE_PASS) begin
      // mode three escapes as URL too
      if (url_reserved(c)) k = KIND_URL;
    end
    return k;
  endfunction

  // number of bytes emitted for a token, minus one
  function automatic logic [2:0] tok_last_idx(input kind_t k);
    logic [2:0] n;
    case (k)
      KIND_PASS: n = 3'd0;
      KIND_QUOT: n = 3'd5;
      KIND_GT:   n = 3'd3;
      KIND_LT:   n = 3'd3;
      KIND_AMP:  n = 3'd4;
      KIND_APOS: n = 3'd5;
      KIND_URL:  n = 3'd2;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) d = 8'("0") + {4'd0, v};
    else           d = 8'("A") + {4'd0, v} - 8'd10;
    return d;
  endfunction

  // entity text left-aligned in six bytes
  function automatic logic [7:0] str_byte(input logic [47:0] s, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = s[47:40];
      3'd1:    b = s[39:32];
      3'd2:    b = s[31:24];
      3'd3:    b = s[23:16];
      3'd4:    b = s[15:8];
      3'd5:    b = s[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tok_byte(input tok_t t, input logic [2:0] idx);
    logic [7:0] b;
    case (t.kind)
      KIND_PASS: b = t.ch;
      KIND_QUOT: b = str_byte("&quot;", idx);
      KIND_GT:   b = str_byte({"&gt;", 16'd0}, idx);
      KIND_LT:   b = str_byte({"&lt;", 16'd0}, idx);
      KIND_AMP:  b = str_byte({"&amp;", 8'd0}, idx);
      KIND_APOS: b = str_byte("&apos;", idx);
      KIND_URL: begin
        if (idx == 3'd0)      b = "%";
        else if (idx == 3'd1) b = hex_digit(t.ch[7:4]);
        else                  b = hex_digit(t.ch[3:0]);
      end
      default:   b = t.ch;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/html_url_escape_stream.sv @@
// Top level of the HTML entity / URL percent escape stream.
//
//   channel  handshake          payload                        dir
//   in       in_push / in_full  in_word  {in_char, final_char} in
//   out      out_pop / out_empty out_word {out_char, run_last, call_done} out
//   cfg      APB write/read     escape_mode at address 0      in
//
// A plain character yields one output byte; an escaped one yields its entity
// or percent bytes (3 for URL, 4 to 6 for HTML), set by the byte expander.
// First byte passes the front register, token queue and output register.
// Reset is synchronous; it empties the token queue and output register and
// sets escape_mode to pass-through. Output stalls back up through the queue.
`default_nettype none
module html_url_escape_stream #(
  parameter int QDEPTH = hues_pkg::Q_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire hues_pkg::in_word_t  in_word,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output hues_pkg::out_word_t      out_word,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [2:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  import hues_pkg::*;

  logic [1:0] mode_r;
  logic       cfg_wr;
  logic       fr_valid, q_full, q_empty, q_pop;
  tok_t       fr_tok, q_tok;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ESCAPE_MODE) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
    end else if (cfg_wr && cfg_paddr[2] == REG_ESCAPE_MODE) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  hues_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .tok_valid (fr_valid),
    .tok       (fr_tok),
    .q_full    (q_full)
  );

  hues_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_valid),
    .wdata (fr_tok),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_tok),
    .empty (q_empty)
  );

  hues_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (!q_empty),
    .tok       (q_tok),
    .tok_pop   (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

@@ rtl/hues_front.sv @@
// Front stage: accepts input words, classifies them into escape tokens.
`default_nettype none
module hues_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        mode,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire hues_pkg::in_word_t in_word,
  output logic                   tok_valid,
  output hues_pkg::tok_t         tok,
  input  wire logic              q_full
);
  import hues_pkg::*;

  logic fr_valid_r, fr_valid_nxt;
  tok_t tok_r;
  logic accept, advance;

  assign in_full = fr_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign advance = fr_valid_r && !q_full;
  assign fr_valid_nxt = accept || (fr_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok_r.kind <= classify(mode, in_word.in_char);
      tok_r.ch   <= in_word.in_char;
      tok_r.fin  <= in_word.final_char;
    end
  end

  assign tok_valid = fr_valid_r;
  assign tok       = tok_r;

endmodule
`default_nettype wire

@@ rtl/hues_queue.sv @@
// Token queue between the classifier and the byte expander.
`default_nettype none
module hues_queue #(
  parameter int QDEPTH = hues_pkg::Q_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hues_pkg::tok_t wdata,
  output logic                full,
  input  wire logic           pop,
  output hues_pkg::tok_t      rdata,
  output logic                empty
);
  import hues_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  tok_t            mem [QDEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end

  assign rdata = mem[rd_ptr_r];

endmodule
`default_nettype wire

@@ rtl/hues_back.sv @@
// Back stage: expands the head token into bytes, one word per cycle while the output is not stalled.
`default_nettype none
module hues_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            tok_valid,
  input  wire hues_pkg::tok_t  tok,
  output logic                 tok_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output hues_pkg::out_word_t  out_word
);
  import hues_pkg::*;

  logic       out_valid_r;
  logic [2:0] idx_q_r, idx_q_nxt;
  logic       out_valid_nxt;
  out_word_t  out_r;
  logic       load, last;

  assign last    = (idx_q_r == tok_last_idx(tok.kind));
  assign load    = tok_valid && (!out_valid_r || out_pop);
  assign tok_pop = load && last;

  always_comb begin
    idx_q_nxt = idx_q_r;
    if (load) idx_q_nxt = last ? 3'd0 : idx_q_r + 3'd1;
    out_valid_nxt = load || (out_valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_q_r     <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_q_r     <= idx_q_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.out_char  <= tok_byte(tok, idx_q_r);
      out_r.run_last  <= last;
      out_r.call_done <= last && tok.fin;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

@@ rtl/hues_checker.sv @@
// Port-level checks for the escape stream, bound to the top level.
`default_nettype none
module hues_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_full,
  input wire logic                out_empty,
  input wire logic                out_pop,
  input wire hues_pkg::out_word_t out_word,
  input wire logic                cfg_pready
);
  import hues_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("output not empty after reset");

  a_not_full_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_full)
    else $error("input full after reset");

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.call_done) |-> out_word.run_last)
    else $error("call_done on a byte that does not end its run");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("stalled output word changed");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready dropped");

endmodule

bind html_url_escape_stream hues_checker u_hues_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_full    (in_full),
  .out_empty  (out_empty),
  .out_pop    (out_pop),
  .out_word   (out_word),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

@@ dv/html_url_escape_stream_tb.sv @@
// Self-checking testbench for the HTML entity / URL percent escape stream.
`timescale 1ns / 1ps
module html_url_escape_stream_tb;
  import hues_pkg::*;

  localparam logic [1:0] MODE_THREE       = 2'd3;
  localparam logic [2:0] ESCAPE_MODE_ADDR = 3'(4 * REG_ESCAPE_MODE);
  localparam logic [7:0] CH_DQUOTE        = 8'h22;
  localparam logic [7:0] CH_APOS          = 8'h27;
  localparam int         IDLE_LIMIT       = 2000;
  localparam int         HOLD_CYCLES      = 120;
  localparam int         DRAIN_CYCLES     = 8;
  localparam int         ITEMS_PER_PHASE  = 14;
  // every character that some mode escapes
  localparam string      RESERVED_CHARS   = "!][#?/,$+=&@:;)('*<>\" %";

  typedef logic [7:0] char_q_t[$];

  class escape_scoreboard;
    out_word_t  expected_bytes[$];
    logic [1:0] mode;
    int         errors;

    function new();
      mode   = MODE_PASS;
      errors = 0;
    endfunction

    function bit is_url_reserved(logic [7:0] c);
      for (int k = 0; k < RESERVED_CHARS.len(); k++)
        if (RESERVED_CHARS[k] == c) return 1'b1;
      return 1'b0;
    endfunction

    function logic [7:0] hex_char(logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v) - 8'd10;
    endfunction

    // expected byte run for one accepted character
    function void note_char(in_word_t w);
      logic [7:0] run[$];
      string      ent;
      bit         last;
      ent = "";
      if (mode == MODE_HTML) begin
        case (w.in_char)
          CH_DQUOTE: ent = "&quot;";
          ">":       ent = "&gt;";
          "<":       ent = "&lt;";
          "&":       ent = "&amp;";
          CH_APOS:   ent = "&apos;";
          default:   ent = "";
        endcase
        if (ent.len() > 0) begin
          for (int k = 0; k < ent.len(); k++) run.push_back(ent[k]);
        end else begin
          run.push_back(w.in_char);
        end
      end else if (mode != MODE_PASS && is_url_reserved(w.in_char)) begin
        run.push_back("%");
        run.push_back(hex_char(w.in_char[7:4]));
        run.push_back(hex_char(w.in_char[3:0]));
      end else begin
        run.push_back(w.in_char);
      end
      foreach (run[k]) begin
        last = (k == run.size() - 1);
        expected_bytes.push_back(out_word_t'{run[k], last, last & w.final_char});
      end
    endfunction

    task report_mismatch(string what);
      $display("%0t: MISMATCH %s", $realtime, what);
      errors++;
    endtask

    task check_byte(out_word_t got);
      out_word_t exp;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
      end else begin
        exp = expected_bytes.pop_front();
        if (got.out_char !== exp.out_char)
          report_mismatch($sformatf("out_char %h, want %h", got.out_char, exp.out_char));
        if (got.run_last !== exp.run_last)
          report_mismatch($sformatf("run_last %b, want %b", got.run_last, exp.run_last));
        if (got.call_done !== exp.call_done)
          report_mismatch($sformatf("call_done %b, want %b", got.call_done, exp.call_done));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  in_word_t    in_word;
  logic        out_empty;
  logic        out_pop;
  out_word_t   out_word;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  escape_scoreboard sb;
  bit               hold_req;
  bit               no_gaps;
  int               idle_cycles;

  html_url_escape_stream i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_word     (in_word),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_word    (out_word),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) < 4)
      return RESERVED_CHARS[$urandom_range(0, RESERVED_CHARS.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // sampled at the edge, before the block updates
  always @(posedge clk) begin
    bit progress;
    progress = 1'b0;
    if (rst_n) begin
      if (in_push && !in_full) begin
        sb.note_char(in_word);
        progress = 1'b1;
      end
      if (out_pop && !out_empty) begin
        sb.check_byte(out_word);
        progress = 1'b1;
      end
      if (cfg_psel && cfg_penable) progress = 1'b1;
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("html_url_escape_stream_tb failed");
        $finish;
      end
    end
  end

  // receiver: random pop pattern, one long hold-off on request
  // the request is checked on every clock of the gap and pop loops, so the hold overlaps the offers
  initial begin
    int gap;
    int run;
    out_pop <= 1'b0;
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) out_pop <= 1'b0;
      for (int k = 0; k < gap && !hold_req; k++) @(posedge clk);
      if (!hold_req) begin
        out_pop <= 1'b1;
        run = $urandom_range(1, 12);
        for (int k = 0; k < run && !hold_req; k++) @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_word <= in_word_t'{c, fin};
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_list(input char_q_t chars);
    foreach (chars[k]) send_char(chars[k], (k % 3 == 2) || (k == chars.size() - 1));
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mode change only once the pipeline is empty
  task automatic set_escape_mode(input logic [1:0] m);
    logic [31:0] rdata;
    in_push <= 1'b0;
    wait_drained();
    cfg_access(1'b1, ESCAPE_MODE_ADDR, 32'(m), rdata);
    sb.mode = m;
    cfg_access(1'b0, ESCAPE_MODE_ADDR, 32'd0, rdata);
    if (rdata[1:0] !== m)
      sb.report_mismatch($sformatf("escape_mode reads %h, want %h", rdata[1:0], m));
  endtask

  initial begin
    logic [1:0] phase_mode[7];
    sb          = new();
    hold_req    = 1'b0;
    no_gaps     = 1'b0;
    idle_cycles = 0;
    phase_mode  = '{MODE_PASS, MODE_HTML, MODE_URL, MODE_THREE, MODE_URL, MODE_HTML,
                    MODE_PASS};
    rst_n       <= 1'b0;
    in_push     <= 1'b0;
    in_word     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_escape_mode(MODE_PASS);
    send_list('{"<", "&", 8'hFF});
    set_escape_mode(MODE_HTML);
    send_list('{CH_DQUOTE, ">", "<", "&", CH_APOS, 8'h00, 8'hFF});
    set_escape_mode(MODE_URL);
    send_list('{" ", "%", "/", "?", "[", CH_DQUOTE, 8'h80, 8'h7F, "A"});
    set_escape_mode(MODE_THREE);
    send_list('{"#", "z"});

    foreach (phase_mode[p]) begin
      set_escape_mode(phase_mode[p]);
      // back-to-back offers against a stalled receiver fill the queue
      no_gaps = (p == 2);
      if (p == 2) hold_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_char(pick_char(), ($urandom_range(0, 3) == 0));
      no_gaps = 1'b0;
    end

    in_push <= 1'b0;
    wait_drained();
    if (sb.errors == 0) begin
      $display("html_url_escape_stream_tb passed");
    end else begin
      $display("html_url_escape_stream_tb failed");
    end
    $finish;
  end

endmodule
